[design/pfe_pkg.sv]
// shared types and constants for the playfair encoder core
// used by pfe_ctrl, pfe_datapath and playfair_cipher_encoder_core
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

    localparam int SIDE     = 5;
    localparam int CELLS    = SIDE * SIDE;
    localparam int LETTERS  = 26;
    localparam int LW       = 5;   // letter / cell index width
    localparam int RCW      = 3;   // row / column width

    localparam logic [LW-1:0] LETTER_Q = 5'd16;
    localparam logic [LW-1:0] LETTER_X = 5'd23;

    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_MSG   = 2'd1,
        OP_END   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic place;
        logic place_walk;
        logic walk_start;
        logic walk_step;
        logic set_closed;
        logic hold;
        logic load_pair;
        logic pair_x;
        logic drop_held;
        logic clear;
        logic out_load;
        logic out_second;
    } pfe_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t           op;
        logic          letter_ok;
        logic          closed;
        logic          held_valid;
        logic          held_eq;
        logic          walk_last;
        logic          out_free;
        logic [LW-1:0] fill;
    } pfe_status_t;

endpackage

`default_nettype wire

[design/pfe_ctrl.sv]
// sequencing state machine of the playfair encoder core
// depends on pfe_pkg; drives pfe_datapath through pfe_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module pfe_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  pfe_pkg::pfe_status_t st,
    output pfe_pkg::pfe_cmd_t    cmd
);
    import pfe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CLOSE,
        S_POS,
        S_CALC,
        S_SQ,
        S_OUT_A,
        S_OUT_B
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_IDLE;
                unique case (st.op)
                    OP_KEY: begin
                        cmd.place = !st.closed;
                    end
                    OP_MSG: begin
                        if (st.letter_ok) begin
                            if (!st.closed) begin
                                cmd.walk_start = 1'b1;
                                state_next     = S_CLOSE;
                            end else if (!st.held_valid) begin
                                cmd.hold = 1'b1;
                            end else begin
                                // equal letters: pair with x, repeat stays held
                                cmd.load_pair = 1'b1;
                                cmd.pair_x    = st.held_eq;
                                cmd.drop_held = !st.held_eq;
                                state_next    = S_POS;
                            end
                        end
                    end
                    OP_END: begin
                        if (st.held_valid) begin
                            cmd.load_pair = 1'b1;
                            cmd.pair_x    = 1'b1;
                            cmd.drop_held = 1'b1;
                            state_next    = S_POS;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CLOSE: begin
                cmd.place      = 1'b1;
                cmd.place_walk = 1'b1;
                cmd.walk_step  = 1'b1;
                if (st.walk_last) begin
                    cmd.set_closed = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_POS:  state_next = S_CALC;
            S_CALC: state_next = S_SQ;
            S_SQ:   state_next = S_OUT_A;
            S_OUT_A: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_OUT_B;
                end
            end
            S_OUT_B: begin
                if (st.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_second = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/pfe_datapath.sv]
// square and position memories, letter bookkeeping and result register
// depends on pfe_pkg; commanded by pfe_ctrl
`timescale 1ns / 1ps
`default_nettype none

module pfe_datapath (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire  [1:0]               in_op,
    input  wire  [pfe_pkg::LW-1:0]   in_letter,
    input  pfe_pkg::pfe_cmd_t        cmd,
    output pfe_pkg::pfe_status_t     st,
    output logic                     m_valid,
    input  wire                      m_ready,
    output logic [pfe_pkg::LW-1:0]   m_letter,
    output logic                     m_last
);
    import pfe_pkg::*;

    logic [LW-1:0] sq_mem  [CELLS];
    logic [LW-1:0] pos_mem [LETTERS];

    logic [1:0]         op_reg;
    logic [LW-1:0]      letter_reg;
    logic [LETTERS-1:0] used_reg;
    logic [LW-1:0]      fill_reg;
    logic               closed_reg;
    logic [LW-1:0]      held_reg;
    logic               held_valid_reg;
    logic [LW-1:0]      walk_reg;
    logic [LW-1:0]      a_reg, b_reg;
    logic [LW-1:0]      pos_a_reg, pos_b_reg;
    logic [LW-1:0]      oa_reg, ob_reg;
    logic [LW-1:0]      oa_next, ob_next;
    logic [LW-1:0]      sq_a_reg, sq_b_reg;
    logic               m_valid_reg;
    logic [LW-1:0]      m_letter_reg;
    logic               m_last_reg;

    logic [LW-1:0]  place_letter;
    logic           place_used;
    logic           do_place;
    logic [RCW-1:0] r1, c1, r2, c2;

    function automatic logic letter_valid(input logic [LW-1:0] l);
        return (l <= LW'(LETTERS - 1)) && (l != LETTER_Q);
    endfunction

    // row by comparison against row starts, column by what is left
    function automatic logic [RCW-1:0] row_of(input logic [LW-1:0] p);
        logic [RCW-1:0] r;
        r = '0;
        for (int i = 1; i < SIDE; i++) begin
            if (p >= LW'(i * SIDE)) r = RCW'(i);
        end
        return r;
    endfunction

    function automatic logic [RCW-1:0] col_of(input logic [LW-1:0] p);
        logic [LW-1:0] base;
        base = LW'(row_of(p) * SIDE);
        return RCW'(p - base);
    endfunction

    function automatic logic [RCW-1:0] wrap_inc(input logic [RCW-1:0] v);
        return (v == RCW'(SIDE - 1)) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [LW-1:0] cell_of(input logic [RCW-1:0] r,
                                              input logic [RCW-1:0] c);
        return LW'(r * SIDE) + LW'(c);
    endfunction

    assign place_letter = cmd.place_walk ? walk_reg : letter_reg;
    assign place_used   = (place_letter <= LW'(LETTERS - 1)) ? used_reg[place_letter] : 1'b1;
    assign do_place     = cmd.place && letter_valid(place_letter) && !place_used
                          && (fill_reg < LW'(CELLS));

    assign r1 = row_of(pos_a_reg);
    assign c1 = col_of(pos_a_reg);
    assign r2 = row_of(pos_b_reg);
    assign c2 = col_of(pos_b_reg);

    always_comb begin
        if (r1 == r2) begin
            oa_next = cell_of(r1, wrap_inc(c1));
            ob_next = cell_of(r2, wrap_inc(c2));
        end else if (c1 == c2) begin
            oa_next = cell_of(wrap_inc(r1), c1);
            ob_next = cell_of(wrap_inc(r2), c2);
        end else begin
            oa_next = cell_of(r1, c2);
            ob_next = cell_of(r2, c1);
        end
    end

    // memories: one write port, two registered read ports each
    always_ff @(posedge aclk) begin
        if (do_place) begin
            sq_mem[fill_reg]      <= place_letter;
            pos_mem[place_letter] <= fill_reg;
        end
        pos_a_reg <= pos_mem[a_reg];
        pos_b_reg <= pos_mem[b_reg];
        sq_a_reg  <= sq_mem[oa_reg];
        sq_b_reg  <= sq_mem[ob_reg];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg     <= in_op;
            letter_reg <= in_letter;
        end
        if (cmd.walk_start) begin
            walk_reg <= '0;
        end else if (cmd.walk_step) begin
            walk_reg <= walk_reg + 1'b1;
        end
        if (cmd.load_pair) begin
            a_reg <= held_reg;
            b_reg <= cmd.pair_x ? LETTER_X : letter_reg;
        end
        oa_reg <= oa_next;
        ob_reg <= ob_next;
        if (cmd.out_load) begin
            m_letter_reg <= cmd.out_second ? sq_b_reg : sq_a_reg;
            m_last_reg   <= cmd.out_second;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            used_reg       <= '0;
            fill_reg       <= '0;
            closed_reg     <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end else begin
            if (do_place) begin
                used_reg[place_letter] <= 1'b1;
                fill_reg               <= fill_reg + 1'b1;
            end
            if (cmd.set_closed) begin
                closed_reg <= 1'b1;
            end
            if (cmd.hold) begin
                held_reg       <= letter_reg;
                held_valid_reg <= 1'b1;
            end else if (cmd.load_pair && cmd.drop_held) begin
                held_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign st.op         = op_t'(op_reg);
    assign st.letter_ok  = letter_valid(letter_reg);
    assign st.closed     = closed_reg;
    assign st.held_valid = held_valid_reg;
    assign st.held_eq    = (held_reg == letter_reg);
    assign st.walk_last  = (walk_reg == LW'(LETTERS - 1));
    assign st.out_free   = !m_valid_reg || m_ready;
    assign st.fill       = fill_reg;

    assign m_valid  = m_valid_reg;
    assign m_letter = m_letter_reg;
    assign m_last   = m_last_reg;

endmodule

`default_nettype wire

[design/playfair_cipher_encoder_core.sv]
// Playfair encryptor over a 5x5 square without Q, built as a controller
// (pfe_ctrl) and a datapath (pfe_datapath); depends on pfe_pkg.
//
// Items arrive with the opcode in s_tuser (key letter, message letter, end of
// message, clear) and the letter in s_tdata. Each item is taken, decoded and
// finished before the next is taken. An item that completes a pair passes
// through the chain position read, cell arithmetic, square read and two result
// slots, and waits in the result slots while m_tready holds the result register.
// The first message letter after a key adds a walk over the alphabet that
// fills the rest of the square, one letter a cycle through the single write
// port, and a second decode. Each pair gives two result items; m_tlast marks
// the second.
`timescale 1ns / 1ps
`default_nettype none

module playfair_cipher_encoder_core (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [4:0] letter, [7:5] zero
    input  wire  [1:0] s_tuser,   // [1:0] opcode
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [4:0] cipher_letter, [7:5] zero
    output logic       m_tlast    // pair_end
);
    import pfe_pkg::*;

    pfe_cmd_t      cmd;
    pfe_status_t   st;
    logic [LW-1:0] m_letter;

    pfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pfe_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_op     (s_tuser),
        .in_letter (s_tdata[LW-1:0]),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_letter  (m_letter),
        .m_last    (m_tlast)
    );

    assign m_tdata = {3'b000, m_letter};

    // a taken item is finished before another is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while previous one still in work");

    // the square never holds more than its cells
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st.fill <= LW'(CELLS))
        else $error("square fill count overflow");

    // a closed square is always full
    a_closed_full: assert property (@(posedge aclk) disable iff (!aresetn)
        st.closed |-> st.fill == LW'(CELLS))
        else $error("square closed while not full");

    // results come from a full square, so they are letters other than q
    a_result_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= 8'd25) && (m_tdata[LW-1:0] != LETTER_Q))
        else $error("result is not a square letter");

endmodule

`default_nettype wire
